### rtl/tcch_pkg.sv
// Package: shared constants, types and tables for the tilt compensated compass.
`default_nettype none
package tcch_pkg;
   localparam int SampleBitsDefault  = 16;
   localparam int CordicStepsDefault = 16;
   localparam int TableLen           = 24;
   localparam int DegUnit            = 65536;
   localparam int OneQ14             = 16384;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MAG_ZERO = 2'd1,
      ST_ACC_ZERO = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] accel_x;
      logic [15:0] accel_y;
      logic [15:0] accel_z;
      logic [15:0] mag_x;
      logic [15:0] mag_y;
      logic [15:0] mag_z;
   } req_type;

   typedef struct packed {
      logic [15:0] heading_cdeg;
      logic [14:0] pitch_cdeg;
      logic [14:0] roll_cdeg;
      logic [1:0]  status;
   } rsp_type;

   // Arctangent of 2^-i in degrees * 2^16.
   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] v;
      v = '0;
      case (i)
         5'd0:  v = 32'sd2949120;
         5'd1:  v = 32'sd1740967;
         5'd2:  v = 32'sd919879;
         5'd3:  v = 32'sd466945;
         5'd4:  v = 32'sd234379;
         5'd5:  v = 32'sd117304;
         5'd6:  v = 32'sd58666;
         5'd7:  v = 32'sd29335;
         5'd8:  v = 32'sd14668;
         5'd9:  v = 32'sd7334;
         5'd10: v = 32'sd3667;
         5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;
         5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;
         5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;
         5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;
         5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;
         5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

### rtl/tcch_if.sv
// Interfaces: valid/ready channels for request and response beats.
`default_nettype none
interface tcch_req_if;
   logic              valid;
   logic              ready;
   tcch_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface tcch_rsp_if;
   logic              valid;
   logic              ready;
   tcch_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/tcch_isqrt.sv
// Module: bit-serial integer square root, one result bit per cycle.
`default_nettype none
module tcch_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [33:0] radicand,
   output logic             done,
   output logic [16:0]      root
);
   logic [35:0] rem_ff, rem_in;
   logic [33:0] val_ff, val_in;
   logic [17:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [35:0] trial;
   logic [35:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      val_in  = val_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[33:0], val_ff[33:32]};
      trial   = 36'({root_ff[15:0], 2'b01});
      if (start) begin
         rem_in  = '0;
         val_in  = radicand;
         root_in = '0;
         cnt_in  = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring step: bring in two bits, try root*4+1
         val_in = {val_ff[31:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[16:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[16:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      val_ff  <= val_in;
      root_ff <= root_in;
   end

   assign done = busy_ff && (cnt_ff == 5'd1);
   assign root = root_in[16:0];

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 5'd0 || cnt_ff == 5'd17 || $past(start))
      else $error("isqrt counter out of step");
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("isqrt done while idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("isqrt did not start");
endmodule
`default_nettype wire

### rtl/tcch_div.sv
// Module: bit-serial unsigned divider, one quotient bit per cycle.
`default_nettype none
module tcch_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [17:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [18:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [17:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [18:0] sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sh      = {rem_ff[17:0], quo_ff[31]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, den_ff}) begin
            rem_in = sh - {1'b0, den_ff};
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = busy_ff && (cnt_ff == 6'd1);
   assign quotient = quo_in;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("divider done while idle");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && cnt_ff == 6'd32)
      else $error("divider did not start");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff != 6'd32 |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder out of range");
endmodule
`default_nettype wire

### rtl/tcch_cordic.sv
// Module: iterative CORDIC vectoring unit returning an angle in degrees*2^16.
`default_nettype none
module tcch_cordic #(
   parameter int CordicSteps = tcch_pkg::CordicStepsDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [44:0] y_in,
   input  wire logic signed [44:0] x_in,
   output logic                    done,
   output logic signed [31:0]      angle
);
   localparam int Steps = (CordicSteps < tcch_pkg::TableLen) ?
                          CordicSteps : tcch_pkg::TableLen;

   logic signed [46:0] x_ff, x_in_n, y_ff, y_in_n;
   logic signed [31:0] z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in, zero_ff, zero_in;
   logic signed [46:0] xs, ys;

   always_comb begin
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      xs      = x_ff >>> i_ff;
      ys      = y_ff >>> i_ff;
      if (start) begin
         i_in    = '0;
         busy_in = 1'b1;
         zero_in = (x_in == 0) && (y_in == 0);
         if (x_in < 0) begin
            // fold the left half plane over
            x_in_n = -47'(x_in);
            y_in_n = -47'(y_in);
            z_in   = 32'sd180 * 32'(tcch_pkg::DegUnit);
         end else begin
            x_in_n = 47'(x_in);
            y_in_n = 47'(y_in);
            z_in   = '0;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_n = x_ff + ys;
            y_in_n = y_ff - xs;
            z_in   = z_ff + tcch_pkg::atan_entry(i_ff);
         end else begin
            x_in_n = x_ff - ys;
            y_in_n = y_ff + xs;
            z_in   = z_ff - tcch_pkg::atan_entry(i_ff);
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(Steps - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         i_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         i_ff    <= i_in;
      end
      x_ff    <= x_in_n;
      y_ff    <= y_in_n;
      z_ff    <= z_in;
      zero_ff <= zero_in;
   end

   assign done  = busy_ff && (i_ff == 5'(Steps - 1));
   assign angle = zero_ff ? 32'sd0 : z_in;

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("cordic done while idle");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> i_ff < 5'(Steps))
      else $error("cordic step out of range");
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && i_ff == 5'd0)
      else $error("cordic did not start");
endmodule
`default_nettype wire

### rtl/tilt_compensated_compass_heading_top.sv
// Top level: tilt compensated compass heading with shared sqrt, divide and CORDIC units.
//
// req channel: one beat carries an accelerometer and a magnetometer triple.
// rsp channel: one beat carries heading, pitch, roll (centidegrees) and status.
// A sequencer walks each beat through a square root unit, a radix-2 divider
// and a CORDIC vectoring unit, plus one multiplier shared by 9 products.
// An ordinary item takes 3 roots, 6 divides and 3 angles; when pitch sits
// at +-90 degrees the roll divide is skipped. A status-only item skips the
// roots, divides and angles and goes straight to the output register.
// req_ready is high only while the sequencer is idle, so one beat is in
// flight at a time. The result is held in an output register with rsp_valid
// until the receiver takes it; while the receiver stalls, the next item
// holds before the output stage and the block waits.
// Reset clears the magnetometer bounds to zero and drops any beat in flight.
// Only the low SAMPLE_BITS bits of each input field are used.
`default_nettype none
module tilt_compensated_compass_heading_top #(
   parameter int SAMPLE_BITS  = tcch_pkg::SampleBitsDefault,
   parameter int CORDIC_STEPS = tcch_pkg::CordicStepsDefault
) (
   input wire logic clock,
   input wire logic reset,
   tcch_req_if.sink   req,
   tcch_rsp_if.source rsp
);
   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_TRACK = 16'h0002,
      S_CHECK = 16'h0004,
      S_SQRTA = 16'h0008,
      S_DIVAX = 16'h0010,
      S_DIVAY = 16'h0020,
      S_SQCP  = 16'h0040,
      S_DIVSR = 16'h0080,
      S_SQCR  = 16'h0100,
      S_DIVN  = 16'h0200,
      S_MUL   = 16'h0400,
      S_ANGP  = 16'h0800,
      S_ANGR  = 16'h1000,
      S_ANGH  = 16'h2000,
      S_CONV  = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] ax_ff, ay_ff, az_ff, mx_ff, my_ff, mz_ff;
   logic signed [15:0] min_ff [3], max_ff [3];
   logic signed [15:0] axn_ff, ayn_ff, sp_ff, cp_ff, sr_ff, cr_ff;
   logic signed [15:0] n_ff [3];
   logic signed [44:0] mxc_ff, myc_ff;
   logic signed [31:0] zp_ff, zr_ff, zh_ff;
   logic [1:0]         idx_ff;
   logic [3:0]         mstep_ff;
   logic signed [44:0] acc_ff;
   logic [1:0]         status_ff;
   logic               sub_go_ff;
   tcch_pkg::rsp_type  out_ff;
   logic               out_valid_ff;

   function automatic logic signed [15:0] sx(input logic [15:0] v);
      logic [15:0] m;
      m = 16'((32'd1 << SAMPLE_BITS) - 1);
      v = v & m;
      if (v[SAMPLE_BITS-1]) return 16'(v | ~m);
      return 16'(v);
   endfunction

   // shared units
   logic        sq_start, sq_done;
   logic [33:0] sq_arg;
   logic [16:0] sq_root;
   logic        dv_start, dv_done;
   logic [31:0] dv_num, dv_q;
   logic [17:0] dv_den;
   logic        co_start, co_done;
   logic signed [44:0] co_y, co_x;
   logic signed [31:0] co_z;

   tcch_isqrt u_sqrt (.clock, .reset, .start(sq_start), .radicand(sq_arg),
                      .done(sq_done), .root(sq_root));
   tcch_div u_div (.clock, .reset, .start(dv_start), .dividend(dv_num),
                   .divisor(dv_den), .done(dv_done), .quotient(dv_q));
   tcch_cordic #(.CordicSteps(CORDIC_STEPS)) u_cordic (.clock, .reset,
      .start(co_start), .y_in(co_y), .x_in(co_x), .done(co_done), .angle(co_z));

   // shared multiplier with combinational operand select feeding the accumulators
   logic signed [17:0] mul_a, mul_b;
   logic signed [35:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic signed [16:0] range_v;
   logic signed [16:0] diff_v;
   logic signed [15:0] num_sel;
   logic [15:0]        num_abs;
   logic signed [31:0] sq_s;
   logic signed [16:0] q_sat;

   always_comb begin
      range_v = 17'(max_ff[idx_ff]) - 17'(min_ff[idx_ff]);
      diff_v  = (idx_ff == 2'd0 ? 17'(mx_ff) : idx_ff == 2'd1 ? 17'(my_ff) :
                 17'(mz_ff)) - 17'(min_ff[idx_ff]);
      num_sel = (state_ff == S_DIVAX) ? ax_ff :
                (state_ff == S_DIVAY) ? ay_ff : ayn_ff;
      num_abs = num_sel[15] ? 16'(-num_sel) : 16'(num_sel);
      q_sat   = (dv_q > 32'd16384) ? 17'sd16384 : 17'(signed'(dv_q[16:0]));
      // operand select for the shared multiplier
      mul_a = '0;
      mul_b = '0;
      sq_s  = '0;
      case (state_ff)
         S_CHECK: begin
            mul_a = 18'(ax_ff);
            mul_b = 18'(ax_ff);
         end
         S_SQCP: begin
            mul_a = 18'(sp_ff);
            mul_b = 18'(sp_ff);
         end
         S_SQCR: begin
            mul_a = 18'(sr_ff);
            mul_b = 18'(sr_ff);
         end
         S_MUL: begin
            case (mstep_ff)
               4'd0: begin mul_a = 18'(n_ff[0]); mul_b = 18'(cp_ff); end
               4'd1: begin mul_a = 18'(n_ff[2]); mul_b = 18'(sp_ff); end
               4'd2: begin mul_a = 18'(sr_ff);   mul_b = 18'(sp_ff); end
               4'd3: begin mul_a = 18'(n_ff[0]); mul_b = acc_ff[31:14]; end
               4'd4: begin mul_a = 18'(n_ff[1]); mul_b = 18'(cr_ff); end
               4'd5: begin mul_a = 18'(sr_ff);   mul_b = 18'(cp_ff); end
               4'd6: begin mul_a = 18'(n_ff[2]); mul_b = acc_ff[31:14]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      sq_s = 32'(mul_p);
   end

   // sum of squares over the three accelerometer axes, held between states
   logic [33:0] sumsq_ff;
   logic [1:0]  sqi_ff;
   logic signed [15:0] sel_a;

   always_comb begin
      sel_a = (sqi_ff == 2'd0) ? ax_ff : (sqi_ff == 2'd1) ? ay_ff : az_ff;
   end

   logic signed [35:0] sq_p;
   assign sq_p = 36'(sel_a) * 36'(sel_a);

   // conversion to centidegrees, one angle per cycle while no result waits for the receiver
   function automatic logic signed [31:0] to_cdeg(input logic signed [31:0] z);
      logic signed [47:0] t;
      t = 48'(z) * 48'sd100 + 48'sd32768;
      return 32'(t >>> 16);
   endfunction

   function automatic logic signed [14:0] clamp90(input logic signed [31:0] v);
      if (v > 32'sd9000) return 15'sd9000;
      if (v < -32'sd9000) return -15'sd9000;
      return 15'(v);
   endfunction

   logic signed [31:0] conv_src;
   logic signed [31:0] conv_out;
   always_comb begin
      conv_src = (idx_ff == 2'd0) ? zp_ff : (idx_ff == 2'd1) ? zr_ff : zh_ff;
      conv_out = to_cdeg(conv_src);
   end

   logic track_lo [3];
   logic track_hi [3];
   logic signed [15:0] mval [3];
   always_comb begin
      mval[0] = mx_ff;
      mval[1] = my_ff;
      mval[2] = mz_ff;
      for (int k = 0; k < 3; k++) begin
         track_lo[k] = mval[k] < min_ff[k];
         track_hi[k] = !track_lo[k] && (mval[k] > max_ff[k]);
      end
   end

   logic mag_zero;
   assign mag_zero = (max_ff[0] == min_ff[0]) || (max_ff[1] == min_ff[1]) ||
                     (max_ff[2] == min_ff[2]);

   // sequencer
   always_comb begin
      state_in = state_ff;
      sq_start = 1'b0;
      sq_arg   = '0;
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      co_start = 1'b0;
      co_y     = '0;
      co_x     = '0;
      case (state_ff)
         S_IDLE:  if (req.valid) state_in = S_TRACK;
         S_TRACK: state_in = S_CHECK;
         S_CHECK: begin
            if (sqi_ff == 2'd3) begin
               if (mag_zero || sumsq_ff == '0) state_in = S_OUT;
               else begin
                  state_in = S_SQRTA;
                  sq_start = 1'b1;
                  sq_arg   = sumsq_ff;
               end
            end
         end
         S_SQRTA: begin
            if (sq_done) begin
               state_in = S_DIVAX;
            end
         end
         S_DIVAX, S_DIVAY, S_DIVSR: begin
            dv_start = sub_go_ff;
            dv_num   = {2'b0, num_abs, 14'b0};
            dv_den   = (state_ff == S_DIVSR) ? 18'(cp_ff) : 18'(acc_ff[17:0]);
            if (dv_done) begin
               if (state_ff == S_DIVAX) state_in = S_DIVAY;
               else if (state_ff == S_DIVAY) state_in = S_SQCP;
               else state_in = S_SQCR;
            end
         end
         S_SQCP, S_SQCR: begin
            sq_start = sub_go_ff;
            sq_arg   = 34'(34'sd268435456 - 34'(sq_s));
            if (sq_done) begin
               if (state_ff == S_SQCR) state_in = S_DIVN;
               else if (sq_root == 17'd0) state_in = S_SQCR;
               else state_in = S_DIVSR;
            end
         end
         S_DIVN: begin
            dv_start = sub_go_ff;
            dv_num   = 32'({15'b0, diff_v} << 15);
            dv_den   = 18'(range_v);
            if (dv_done && idx_ff == 2'd2) state_in = S_MUL;
         end
         S_MUL:   if (mstep_ff == 4'd7) state_in = S_ANGP;
         S_ANGP, S_ANGR, S_ANGH: begin
            co_start = sub_go_ff;
            if (state_ff == S_ANGP) begin
               co_y = 45'(sp_ff) <<< 14;
               co_x = 45'(cp_ff) <<< 14;
            end else if (state_ff == S_ANGR) begin
               co_y = 45'(sr_ff) <<< 14;
               co_x = 45'(cr_ff) <<< 14;
            end else begin
               co_y = myc_ff;
               co_x = mxc_ff;
            end
            if (co_done) begin
               if (state_ff == S_ANGP) state_in = S_ANGR;
               else if (state_ff == S_ANGR) state_in = S_ANGH;
               else state_in = S_CONV;
            end
         end
         // hold the conversion while the previous result still waits
         S_CONV:  if (idx_ff == 2'd2 && !out_valid_ff) state_in = S_OUT;
         S_OUT:   if (!out_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         sub_go_ff    <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= '0;
            max_ff[k] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         sub_go_ff <= (state_in != state_ff) ||
                      (state_ff == S_DIVN && dv_done && idx_ff != 2'd2);
         if (state_ff == S_TRACK) begin
            for (int k = 0; k < 3; k++) begin
               if (track_lo[k]) min_ff[k] <= mval[k];
               else if (track_hi[k]) max_ff[k] <= mval[k];
            end
         end
         if (state_ff == S_OUT && !out_valid_ff) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      // payload path
      case (state_ff)
         S_IDLE: begin
            ax_ff  <= sx(req.data.accel_x);
            ay_ff  <= sx(req.data.accel_y);
            az_ff  <= sx(req.data.accel_z);
            mx_ff  <= sx(req.data.mag_x);
            my_ff  <= sx(req.data.mag_y);
            mz_ff  <= sx(req.data.mag_z);
            sqi_ff <= '0;
            sumsq_ff <= '0;
            idx_ff <= '0;
            mstep_ff <= '0;
            zp_ff <= '0;
            zr_ff <= '0;
            zh_ff <= '0;
         end
         S_TRACK: begin
            sqi_ff <= '0;
         end
         S_CHECK: begin
            if (sqi_ff != 2'd3) begin
               sumsq_ff <= sumsq_ff + 34'(sq_p);
               sqi_ff   <= sqi_ff + 2'd1;
            end
            status_ff <= mag_zero ? tcch_pkg::ST_MAG_ZERO :
                         (sqi_ff == 2'd3 && sumsq_ff == '0) ? tcch_pkg::ST_ACC_ZERO :
                         tcch_pkg::ST_OK;
         end
         S_SQRTA: if (sq_done) acc_ff <= 45'(sq_root);
         S_DIVAX: if (dv_done) axn_ff <= ax_ff[15] ? 16'(-q_sat) : 16'(q_sat);
         S_DIVAY: if (dv_done) begin
            ayn_ff <= ay_ff[15] ? 16'(-q_sat) : 16'(q_sat);
            sp_ff  <= -axn_ff;
         end
         S_SQCP: if (sq_done) begin
            cp_ff <= 16'(sq_root);
            if (sq_root == 17'd0)
               sr_ff <= (ayn_ff == 0) ? 16'sd0 : (ayn_ff[15] ? -16'sd16384 : 16'sd16384);
         end
         S_DIVSR: if (dv_done) sr_ff <= ayn_ff[15] ? 16'(-q_sat) : 16'(q_sat);
         S_SQCR: if (sq_done) begin
            cr_ff  <= 16'(sq_root);
            idx_ff <= '0;
         end
         S_DIVN: if (dv_done) begin
            n_ff[idx_ff] <= 16'(dv_q - 32'd16384);
            idx_ff <= idx_ff + 2'd1;
            mstep_ff <= '0;
         end
         S_MUL: begin
            mstep_ff <= mstep_ff + 4'd1;
            case (mstep_ff)
               4'd0: mxc_ff <= 45'(mul_p);
               4'd1: mxc_ff <= mxc_ff + 45'(mul_p);
               4'd2: acc_ff <= 45'(mul_p);
               4'd3: myc_ff <= 45'(mul_p);
               4'd4: myc_ff <= myc_ff + 45'(mul_p);
               4'd5: acc_ff <= 45'(mul_p);
               4'd6: myc_ff <= myc_ff - 45'(mul_p);
               default: ;
            endcase
            idx_ff <= '0;
         end
         S_ANGP: if (co_done) zp_ff <= co_z;
         S_ANGR: if (co_done) zr_ff <= co_z;
         S_ANGH: if (co_done) begin
            if (co_z < 0) zh_ff <= co_z + 32'sd23592960;
            else if (co_z >= 32'sd23592960) zh_ff <= co_z - 32'sd23592960;
            else zh_ff <= co_z;
         end
         S_CONV: if (!out_valid_ff) begin
            idx_ff <= idx_ff + 2'd1;
            case (idx_ff)
               2'd0: out_ff.pitch_cdeg <= clamp90(conv_out);
               2'd1: out_ff.roll_cdeg  <= clamp90(conv_out);
               default: out_ff.heading_cdeg <=
                  (conv_out >= 32'sd36000) ? 16'(conv_out - 32'sd36000) : 16'(conv_out);
            endcase
         end
         S_OUT: if (!out_valid_ff) begin
            out_ff.status <= status_ff;
            if (status_ff != tcch_pkg::ST_OK) begin
               out_ff.heading_cdeg <= '0;
               out_ff.pitch_cdeg   <= '0;
               out_ff.roll_cdeg    <= '0;
            end
         end
         default: ;
      endcase
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == S_TRACK)
      else $error("accepted beat not tracked");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result dropped under stall");
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      min_ff[0] <= max_ff[0] && min_ff[1] <= max_ff[1] && min_ff[2] <= max_ff[2])
      else $error("mag bounds crossed");
endmodule
`default_nettype wire

### test/tilt_compensated_compass_heading_top_tb.sv
// Testbench: random and directed compass beats checked against a heading predictor.
`timescale 1ns / 1ps
module tilt_compensated_compass_heading_top_tb;

   // Arctangent table, degrees * 2^16, one entry per CORDIC step.
   localparam longint AtanTab[24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   // Predictor of the compass math plus the queue of expected response beats.
   class heading_scoreboard;
      longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
      tcch_pkg::rsp_type pending[$];
      int mismatches;

      function void clear();
         lo_x = 0; lo_y = 0; lo_z = 0; hi_x = 0; hi_y = 0; hi_z = 0;
         pending.delete();
         mismatches = 0;
      endfunction

      function longint fshift(longint v, int s);
         return v >>> s;
      endfunction

      function longint root(longint v);
         longint r, b;
         r = 0;
         b = 64'sh4000_0000_0000_0000;
         while (b > v) b = b >>> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >>> 1) + b;
            end else begin
               r = r >>> 1;
            end
            b = b >>> 2;
         end
         return r;
      endfunction

      function longint angle(longint y, longint x);
         longint z, xs, ys;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            x = -x; y = -y; z = 180 * 65536;
         end
         for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
               x += ys; y -= xs; z += AtanTab[i];
            end else begin
               x -= ys; y += xs; z -= AtanTab[i];
            end
         end
         return z;
      endfunction

      function longint cdeg(longint z);
         longint n;
         n = z * 100 + 32768;
         return (n >= 0) ? n / 65536 : -((-n + 65535) / 65536);
      endfunction

      function longint clamp90(longint v);
         if (v > 9000) return 9000;
         if (v < -9000) return -9000;
         return v;
      endfunction

      function longint ratio(longint num, longint den);
         longint q;
         q = ((num < 0 ? -num : num) * 16384) / den;
         if (q > 16384) q = 16384;
         return num < 0 ? -q : q;
      endfunction

      function void bound(longint m, ref longint lo, ref longint hi);
         if (m < lo) lo = m;
         else if (m > hi) hi = m;
      endfunction

      // Advance the bounds and queue the expected beat for one request.
      function void note_request(tcch_pkg::req_type r);
         longint ax, ay, az, mx, my, mz, rx, ry, rz, sum, amag;
         longint sp, cp, sr, cr, nx, ny, nz, mxc, myc, z, hd, pt, rl;
         tcch_pkg::rsp_type e;
         ax = longint'($signed(r.accel_x)); ay = longint'($signed(r.accel_y));
         az = longint'($signed(r.accel_z)); mx = longint'($signed(r.mag_x));
         my = longint'($signed(r.mag_y)); mz = longint'($signed(r.mag_z));
         bound(mx, lo_x, hi_x); bound(my, lo_y, hi_y); bound(mz, lo_z, hi_z);
         rx = hi_x - lo_x; ry = hi_y - lo_y; rz = hi_z - lo_z;
         sum = ax * ax + ay * ay + az * az;
         hd = 0; pt = 0; rl = 0;
         if (rx == 0 || ry == 0 || rz == 0) begin
            e.status = tcch_pkg::ST_MAG_ZERO;
         end else if (sum == 0) begin
            e.status = tcch_pkg::ST_ACC_ZERO;
         end else begin
            e.status = tcch_pkg::ST_OK;
            amag = root(sum);
            sp = -ratio(ax, amag);
            cp = root(64'sd268435456 - sp * sp);
            if (cp == 0) begin
               nz = ratio(ay, amag);
               sr = (nz == 0) ? 0 : (nz < 0 ? -16384 : 16384);
            end else begin
               sr = ratio(ratio(ay, amag), cp);
            end
            cr = root(64'sd268435456 - sr * sr);
            nx = ((mx - lo_x) * 32768) / rx - 16384;
            ny = ((my - lo_y) * 32768) / ry - 16384;
            nz = ((mz - lo_z) * 32768) / rz - 16384;
            mxc = nx * cp + nz * sp;
            myc = nx * fshift(sr * sp, 14) + ny * cr - nz * fshift(sr * cp, 14);
            pt = clamp90(cdeg(angle(sp * 16384, cp * 16384)));
            rl = clamp90(cdeg(angle(sr * 16384, cr * 16384)));
            z = angle(myc, mxc);
            if (z < 0) z += 360 * 65536;
            if (z >= 360 * 65536) z -= 360 * 65536;
            hd = cdeg(z);
            if (hd >= 36000) hd -= 36000;
         end
         e.heading_cdeg = hd[15:0];
         e.pitch_cdeg = pt[14:0];
         e.roll_cdeg = rl[14:0];
         pending.push_back(e);
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_response(tcch_pkg::rsp_type got);
         tcch_pkg::rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
            return;
         end
         e = pending.pop_front();
         if (got.heading_cdeg !== e.heading_cdeg || got.pitch_cdeg !== e.pitch_cdeg ||
             got.roll_cdeg !== e.roll_cdeg || got.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected hdg %0d pit %0d rol %0d st %0d, got %0d %0d %0d %0d",
                        e.heading_cdeg, $signed(e.pitch_cdeg), $signed(e.roll_cdeg), e.status,
                        got.heading_cdeg, $signed(got.pitch_cdeg), $signed(got.roll_cdeg),
                        got.status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic driving_done = 1'b0;
   heading_scoreboard board;

   tcch_req_if req ();
   tcch_rsp_if rsp ();

   tilt_compensated_compass_heading_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Note every accepted request and check every response beat at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) board.note_request(req.data);
         if (rsp.valid && rsp.ready) board.check_response(rsp.data);
      end
   end

   // Send one request beat: idle a random gap, then hold valid until taken.
   // Valid stays high into the next beat when the gap is zero.
   task automatic send_beat(tcch_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 18);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_fields(int ax, int ay, int az, int mx, int my, int mz);
      tcch_pkg::req_type r;
      r.accel_x = ax[15:0]; r.accel_y = ay[15:0]; r.accel_z = az[15:0];
      r.mag_x = mx[15:0]; r.mag_y = my[15:0]; r.mag_z = mz[15:0];
      send_beat(r);
   endtask

   // Stall the receiver at random, with spells of no stalling at all.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int v;
      board = new();
      board.clear();
      req.valid = 1'b0;
      req.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero range on every axis at first, then zero acceleration.
      send_fields(100, 200, 300, 0, 0, 0);
      send_fields(0, 0, 0, 500, -400, 300);
      send_fields(0, 0, 0, -500, 400, -300);
      // Level, then pitch at both ends of the asin range (cos of pitch zero).
      send_fields(0, 0, 16384, 100, 50, -20);
      send_fields(16384, 0, 0, 20, -100, 60);
      send_fields(-16384, 0, 0, -20, 100, -60);
      send_fields(16384, 5, 0, 0, 0, 0);
      send_fields(-32768, -1, 0, 0, 0, 0);
      // Field extremes on both sensors.
      send_fields(32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(-32768, -32768, -32768, -32768, -32768, -32768);
      send_fields(-32768, 32767, -1, 1, -1, 0);
      send_fields(0, 32767, 0, 0, 0, 0);
      send_fields(0, -32768, 1, 32767, -32768, 32767);
      // Magnetic vector straight along the axes, hunting heading wrap at north.
      send_fields(0, 0, 1000, 32767, 0, 0);
      send_fields(0, 0, 1000, 0, -1, 0);
      send_fields(0, 0, -1000, 0, 0, 0);
      send_fields(1, 1, 1, -1, -1, -1);

      // Mostly realistic magnitudes, some full scale noise.
      for (int n = 0; n < 2000; n++) begin
         tcch_pkg::req_type r;
         if ($urandom_range(0, 9) < 7) begin
            v = $urandom_range(0, 8000);
            r.accel_x = 16'($urandom_range(0, 2 * v) - v);
            r.accel_y = 16'($urandom_range(0, 2 * v) - v);
            r.accel_z = 16'($urandom_range(0, 32000) - 16000);
            r.mag_x = 16'($urandom_range(0, 4000) - 2000);
            r.mag_y = 16'($urandom_range(0, 4000) - 2000);
            r.mag_z = 16'($urandom_range(0, 4000) - 2000);
         end else begin
            r = tcch_pkg::req_type'({$urandom, $urandom, $urandom});
         end
         send_beat(r);
      end
      req.valid <= 1'b0;
      driving_done = 1'b1;
   end

   // Drain: wait for the last response, then a quiet spell.
   initial begin
      wait (driving_done);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Hard stop: a time limit for about 2020 beats with their random gaps and stalls.
   initial begin
      #8000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
